>>> src/mspd_pkg.sv
// shared types and constants for the multi-source pixel compare block
`default_nettype none
package mspd_pkg;

	// configuration register indexes
	localparam logic CFG_PACK_MODE    = 1'b0;
	localparam logic CFG_SOURCE_COUNT = 1'b1;

	// pack modes
	localparam logic [1:0] MODE_INTENSITY = 2'd0;
	localparam logic [1:0] MODE_TIGHT     = 2'd1;
	localparam logic [1:0] MODE_NO_ALPHA  = 2'd2;

	// queue between front and divider
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] byte_0;
		logic [7:0] byte_1;
		logic [7:0] byte_2;
		logic [7:0] byte_3;
		logic       past_end;
	} item_t;

	typedef struct packed {
		logic [7:0] green_level;
		logic [7:0] mismatch_count;
	} result_t;

	// one finished pixel position waiting for the green level divide
	typedef struct packed {
		logic [7:0] mismatch_count;
		logic [7:0] source_count;
	} div_req_t;

	// front to top status
	typedef struct packed {
		logic       done;
		div_req_t   req;
	} front_out_t;

endpackage
`default_nettype wire

>>> src/multi_source_pixel_diff.sv
// top level of the multi-source pixel compare block
`default_nettype none
// One request per source arrives in order for a pixel position; each is packed into
// an rgba pixel by the pixel format setting (padding when past_end), compared with the
// first source's pixel, and after source_count requests (each request alone when it is
// zero) one result leaves with the mismatch count and green_level = floor(255*count/
// source_count), 255 when the count is not below the source count and 0 when
// source_count is zero. The front end takes one request per cycle while the queue is
// not full. Each finished position goes through a four-entry queue to a restoring
// divider that retires one quotient bit per cycle; it takes the next position only
// once its last result has gone to the output register, and skips the divide when
// the count is zero or not below the source count. full rises while the queue is full.
// Results wait in an output register read through empty/pop. The configuration port
// is always ready; index 0 is the pixel format, index 1 source_count.
module multi_source_pixel_diff import mspd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request side
	input  wire logic       push,
	input  wire item_t      item,
	output logic            full,
	// result side
	input  wire logic       pop,
	output result_t         result,
	output logic            empty,
	// configuration writes
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic [1:0]  pix_format_q;
	logic [7:0]  source_count_q;
	logic        accept;
	front_out_t  front_st;
	div_req_t    q_rd_data;
	logic        q_full;
	logic        q_empty;
	logic        div_take;
	logic        div_valid;
	result_t     div_res;
	logic        out_free;
	logic        out_valid_q;
	result_t     out_q;

	// configuration registers, writes only land between positions or mid-position
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_format_q   <= MODE_INTENSITY;
			source_count_q <= 8'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PACK_MODE:    pix_format_q   <= cfg_data[1:0];
				CFG_SOURCE_COUNT: source_count_q <= cfg_data;
				default:          pix_format_q   <= pix_format_q;
			endcase
		end
	end

	// request side stalls only on a full divider queue
	assign full   = q_full;
	assign accept = push & ~q_full;

	mspd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.pix_format   (pix_format_q),
		.source_count (source_count_q),
		.status       (front_st)
	);

	mspd_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_st.done),
		.wr_data (front_st.req),
		.rd_en   (div_take),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	mspd_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_avail (~q_empty),
		.req       (q_rd_data),
		.req_take  (div_take),
		.res_valid (div_valid),
		.res       (div_res),
		.res_ready (out_free)
	);

	// output register, refilled in the cycle it is popped
	assign out_free = ~out_valid_q | pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && div_valid) begin
			out_q <= div_res;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = out_q;

	// a match never shows a green level
	a_zero_count_black: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mismatch_count == 8'd0) |-> (result.green_level == 8'd0))
		else $error("nonzero green level with zero mismatches");

	// a waiting result is not lost or changed before it is popped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result dropped or changed");

	// a finished position never meets a full queue
	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		front_st.done |-> !q_full)
		else $error("position finished into a full queue");

endmodule
`default_nettype wire

>>> src/mspd_front.sv
// front end: packs each source item, compares it to the first source, counts mismatches
`default_nettype none
module mspd_front import mspd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire item_t      item,
	input  wire logic [1:0] pix_format,
	input  wire logic [7:0] source_count,
	output front_out_t      status
);

	logic [31:0] ref_q;
	logic [7:0]  cnt_q;
	logic [7:0]  idx_q;
	logic [31:0] px;
	logic        first;
	logic        last;
	logic [7:0]  cnt_nxt;
	logic [8:0]  idx_inc;

	// rgba with red in the low byte
	function automatic logic [31:0] to_rgba(input item_t it, input logic [1:0] mode);
		logic [31:0] p;
		p = {8'hff, it.byte_0, it.byte_0, it.byte_0};
		if (it.past_end) begin
			p = {8'hff, 24'h000000};
		end else begin
			unique case (mode)
				MODE_TIGHT:    p = {it.byte_3, it.byte_2, it.byte_1, it.byte_0};
				MODE_NO_ALPHA: p = {8'hff, it.byte_2, it.byte_1, it.byte_0};
				default:       p = {8'hff, it.byte_0, it.byte_0, it.byte_0};
			endcase
		end
		return p;
	endfunction

	always_comb begin
		px      = to_rgba(item, pix_format);
		first   = (idx_q == 8'd0);
		cnt_nxt = first ? 8'd0 : (cnt_q + {7'd0, (px != ref_q)});
		idx_inc = {1'b0, idx_q} + 9'd1;
		last    = (idx_inc >= {1'b0, source_count});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			if (first) begin
				ref_q <= px;
			end
			if (last) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else begin
				idx_q <= idx_inc[7:0];
				cnt_q <= cnt_nxt;
			end
		end
	end

	assign status.done               = accept & last;
	assign status.req.mismatch_count = cnt_nxt;
	assign status.req.source_count   = source_count;

endmodule
`default_nettype wire

>>> src/mspd_fifo.sv
// short request queue between the front end and the divider
`default_nettype none
module mspd_fifo import mspd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_en,
	input  wire div_req_t wr_data,
	input  wire logic     rd_en,
	output div_req_t      rd_data,
	output logic          full,
	output logic          empty
);

	div_req_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_wr;
	logic                   do_rd;

	assign full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> src/mspd_divider.sv
// back end: radix-2 restoring divide for floor(255*count/sources), one bit per cycle
`default_nettype none
module mspd_divider import mspd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_avail,
	input  wire div_req_t req,
	output logic          req_take,
	output logic          res_valid,
	output result_t       res,
	input  wire logic     res_ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  st_q;
	logic [2:0]  step_q;
	logic [7:0]  rem_q;
	logic [7:0]  lo_q;
	logic [7:0]  quo_q;
	logic [7:0]  cnt_q;
	logic [7:0]  div_q;
	logic [15:0] dividend;
	logic [8:0]  trial;
	logic        qbit;
	logic [7:0]  rem_nxt;

	// 255*c = 256*c - c
	assign dividend = {req.mismatch_count, 8'd0} - {8'd0, req.mismatch_count};
	assign req_take = (st_q == ST_IDLE) & req_avail;

	always_comb begin
		trial   = {rem_q, lo_q[7]};
		qbit    = (trial >= {1'b0, div_q});
		rem_nxt = qbit ? 8'(trial - {1'b0, div_q}) : trial[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (req_avail) begin
						if (req.source_count == 8'd0 || req.mismatch_count == 8'd0 ||
						    req.mismatch_count >= req.source_count) begin
							st_q <= ST_DONE;
						end else begin
							st_q <= ST_DIV;
						end
						step_q <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			cnt_q <= req.mismatch_count;
			div_q <= req.source_count;
			rem_q <= dividend[15:8];
			lo_q  <= dividend[7:0];
			// quotient saturates once count reaches the source count
			if (req.source_count == 8'd0 || req.mismatch_count == 8'd0) begin
				quo_q <= 8'd0;
			end else if (req.mismatch_count >= req.source_count) begin
				quo_q <= 8'hff;
			end else begin
				quo_q <= 8'd0;
			end
		end else if (st_q == ST_DIV) begin
			rem_q <= rem_nxt;
			lo_q  <= {lo_q[6:0], 1'b0};
			quo_q <= {quo_q[6:0], qbit};
		end
	end

	assign res_valid          = (st_q == ST_DONE);
	assign res.green_level    = quo_q;
	assign res.mismatch_count = cnt_q;

endmodule
`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the multi-source pixel compare block
module testbench;
	import mspd_pkg::*;

	// cycles to let the front end settle once no result is outstanding
	localparam int SETTLE_CYCLES  = 32;
	// longest stretch without any accepted request before giving up
	localparam int WATCHDOG_LIMIT = 4000;

	logic       clk;
	logic       arst_n;
	logic       push;
	item_t      item;
	logic       full;
	logic       pop;
	result_t    result;
	logic       empty;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;

	multi_source_pixel_diff uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.pop       (pop),
		.result    (result),
		.empty     (empty),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block: configuration and per-position compare state
	logic [1:0]  cur_mode;
	logic [7:0]  cur_count;
	logic [31:0] ref_pixel;
	logic [7:0]  diff_cnt;
	logic [7:0]  src_idx;

	// green level / mismatch count pairs still owed by the block
	result_t pending_results[$];

	int items_sent;
	int results_checked;
	int cfg_writes;
	int error_count;
	int idle_cycles;
	int burst_left;
	bit steady_sender;
	int pop_mode;
	logic [15:0] stall_pat;
	int pop_cyc;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// pack one source into rgba, r in the low byte
	function automatic logic [31:0] pack_source(item_t it, logic [1:0] mode);
		if (it.past_end)
			return {8'hff, 8'h00, 8'h00, 8'h00};
		case (mode)
			MODE_TIGHT:    return {it.byte_3, it.byte_2, it.byte_1, it.byte_0};
			MODE_NO_ALPHA: return {8'hff, it.byte_2, it.byte_1, it.byte_0};
			// intensity, and the unused fourth mode falls back to it
			default:       return {8'hff, it.byte_0, it.byte_0, it.byte_0};
		endcase
	endfunction

	// advance the shadow state by one source, queue a result at end of position
	task automatic predict_compare(item_t it);
		logic [31:0] px;
		int unsigned green;
		result_t r;
		px = pack_source(it, cur_mode);
		if (src_idx == 8'd0) begin
			ref_pixel = px;
			diff_cnt  = 8'd0;
		end else if (px != ref_pixel) begin
			diff_cnt = diff_cnt + 8'd1;
		end
		if ({1'b0, src_idx} + 9'd1 < {1'b0, cur_count}) begin
			src_idx = src_idx + 8'd1;
		end else begin
			// too few sources or a clean match gives black
			if (cur_count == 8'd0 || diff_cnt == 8'd0)
				green = 0;
			else
				green = (255 * int'(diff_cnt)) / int'(cur_count);
			// count lowered mid-position can push the ratio past full scale
			if (green > 255)
				green = 255;
			r.green_level    = green[7:0];
			r.mismatch_count = diff_cnt;
			pending_results.push_back(r);
			src_idx  = 8'd0;
			diff_cnt = 8'd0;
		end
	endtask

	function automatic item_t make_item(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		logic [7:0] b3, logic pe);
		item_t it;
		it.byte_0   = b0;
		it.byte_1   = b1;
		it.byte_2   = b2;
		it.byte_3   = b3;
		it.past_end = pe;
		return it;
	endfunction

	// send one source request; the sender runs in bursts with random gaps
	task automatic send_source(item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		// accepted at the first rising edge with full low
		do @(posedge clk); while (full !== 1'b0);
		items_sent++;
		predict_compare(it);
		@(negedge clk);
	endtask

	// one configuration request, only while nothing is outstanding
	task automatic write_reg(logic idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_writes++;
		if (idx == CFG_PACK_MODE)
			cur_mode = data[1:0];
		else
			cur_count = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold the sender until every owed result is back, then let the front end settle
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(logic [1:0] mode, logic [7:0] count);
		wait_idle();
		write_reg(CFG_PACK_MODE, {6'd0, mode});
		write_reg(CFG_SOURCE_COUNT, count);
	endtask

	// ---------------------------------------------------------------------------
	// directed tests
	// ---------------------------------------------------------------------------

	// reset values: intensity mode, two sources per position
	task automatic test_reset_config();
		send_source(make_item(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_source(make_item(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
	endtask

	// each pack mode decides which bytes take part in the compare
	task automatic test_pack_modes();
		set_config(MODE_INTENSITY, 8'd2);
		// only byte_0 counts in intensity mode
		send_source(make_item(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
		send_source(make_item(8'h10, 8'hff, 8'h00, 8'h11, 1'b0));
		send_source(make_item(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_source(make_item(8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
		set_config(MODE_TIGHT, 8'd2);
		// alpha byte alone makes a difference
		send_source(make_item(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
		send_source(make_item(8'hff, 8'hff, 8'hff, 8'h00, 1'b0));
		set_config(MODE_NO_ALPHA, 8'd2);
		// alpha ignored, third byte not
		send_source(make_item(8'h01, 8'h02, 8'h03, 8'h00, 1'b0));
		send_source(make_item(8'h01, 8'h02, 8'h03, 8'hff, 1'b0));
		send_source(make_item(8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
		send_source(make_item(8'h01, 8'h02, 8'h04, 8'h04, 1'b0));
		// unused mode packs as intensity
		set_config(2'd3, 8'd2);
		send_source(make_item(8'h05, 8'h06, 8'h07, 8'h08, 1'b0));
		send_source(make_item(8'h05, 8'h00, 8'h00, 8'h00, 1'b0));
	endtask

	// padding is opaque black whatever the bytes say
	task automatic test_padding();
		set_config(MODE_INTENSITY, 8'd2);
		send_source(make_item(8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
		send_source(make_item(8'h00, 8'h5a, 8'ha5, 8'h00, 1'b0));
		set_config(MODE_TIGHT, 8'd2);
		send_source(make_item(8'h00, 8'h00, 8'h00, 8'hff, 1'b0));
		send_source(make_item(8'h3c, 8'hc3, 8'h81, 8'h7e, 1'b1));
	endtask

	// zero or one source: every request closes a position on its own
	task automatic test_few_sources();
		set_config(MODE_TIGHT, 8'd0);
		send_source(make_item(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
		send_source(make_item(8'h87, 8'h65, 8'h43, 8'h21, 1'b1));
		set_config(MODE_TIGHT, 8'd1);
		send_source(make_item(8'haa, 8'h55, 8'haa, 8'h55, 1'b0));
	endtask

	// configuration changed while a position is half done
	task automatic test_mid_position_changes();
		// source count lowered below the mismatches seen so far saturates green
		set_config(MODE_TIGHT, 8'd4);
		send_source(make_item(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_source(make_item(8'h01, 8'h00, 8'h00, 8'h00, 1'b0));
		send_source(make_item(8'h02, 8'h00, 8'h00, 8'h00, 1'b0));
		wait_idle();
		write_reg(CFG_SOURCE_COUNT, 8'd2);
		send_source(make_item(8'h03, 8'h00, 8'h00, 8'h00, 1'b0));
		// pack mode switch keeps the stored reference as it was packed
		set_config(MODE_NO_ALPHA, 8'd2);
		send_source(make_item(8'h07, 8'h07, 8'h07, 8'h99, 1'b0));
		wait_idle();
		write_reg(CFG_PACK_MODE, {6'd0, MODE_INTENSITY});
		send_source(make_item(8'h07, 8'h00, 8'h00, 8'h00, 1'b0));
	endtask

	// ---------------------------------------------------------------------------
	// random traffic
	// ---------------------------------------------------------------------------

	function automatic item_t random_base();
		item_t it;
		if ($urandom_range(0, 9) == 0) begin
			it = ($urandom_range(0, 1) == 0) ? make_item(8'h00, 8'h00, 8'h00, 8'h00, 1'b0)
				: make_item(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
		end else begin
			it = item_t'({1'b0, $urandom});
			it.byte_3 = 8'($urandom_range(0, 255));
			it.past_end = 1'b0;
		end
		it.past_end = ($urandom_range(0, 9) == 0);
		return it;
	endfunction

	// a later source: a copy of the first, a near miss, padding or a fresh random pixel
	function automatic item_t vary_source(item_t base);
		item_t v;
		int sel;
		sel = $urandom_range(0, 99);
		v = base;
		if (sel < 45) begin
			v = base;
		end else if (sel < 60) begin
			v = random_base();
			v.past_end = 1'b1;
		end else if (sel < 85) begin
			v.past_end = 1'b0;
			case ($urandom_range(0, 3))
				0: v.byte_0 = 8'($urandom_range(0, 255));
				1: v.byte_1 = 8'($urandom_range(0, 255));
				2: v.byte_2 = 8'($urandom_range(0, 255));
				default: v.byte_3 = 8'($urandom_range(0, 255));
			endcase
		end else begin
			v = random_base();
		end
		return v;
	endfunction

	// one setting, then whole positions of random content until the budget is spent
	task automatic run_phase(logic [1:0] mode, logic [7:0] count, int budget);
		logic [7:0] mode_word;
		int sent;
		int pos_len;
		int pos;
		int pause_pos;
		item_t base;
		wait_idle();
		// upper bits of the pack mode write are don't care
		mode_word = {6'($urandom_range(0, 63)), mode};
		if ($urandom_range(0, 1) == 0) begin
			write_reg(CFG_PACK_MODE, mode_word);
			write_reg(CFG_SOURCE_COUNT, count);
		end else begin
			write_reg(CFG_SOURCE_COUNT, count);
			write_reg(CFG_PACK_MODE, mode_word);
		end
		steady_sender = ($urandom_range(0, 3) == 0);
		pause_pos = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : -1;
		sent = 0;
		pos = 0;
		while (sent < budget) begin
			pos_len = (count < 8'd2) ? 1 : int'(count);
			// a few positions are cut short and run into the next one
			if ($urandom_range(0, 19) == 0)
				pos_len = $urandom_range(1, pos_len);
			base = random_base();
			send_source(base);
			sent++;
			for (int i = 1; i < pos_len; i++) begin
				send_source(vary_source(base));
				sent++;
			end
			pos++;
			// sender holds off until the block has handed back everything
			if (pos == pause_pos)
				wait_idle();
		end
		steady_sender = 1'b0;
	endtask

	task automatic test_random_traffic();
		int count;
		// extremes of the source count first
		run_phase(MODE_TIGHT, 8'd255, 255);
		run_phase(MODE_NO_ALPHA, 8'd2, 130);
		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 9))
				0:       count = $urandom_range(0, 1);
				1:       count = $urandom_range(9, 40);
				default: count = $urandom_range(2, 8);
			endcase
			run_phase(2'($urandom_range(0, 3)), 8'(count), 125);
		end
	endtask

	// ---------------------------------------------------------------------------
	// result side: stall pattern and checker
	// ---------------------------------------------------------------------------

	// receiver alternates between free running, a rotating stall mask and coin flips
	always @(negedge clk) begin
		if (pop_cyc % 200 == 0) begin
			pop_mode  = $urandom_range(0, 2);
			stall_pat = 16'($urandom) | 16'h0001;
		end
		pop_cyc++;
		case (pop_mode)
			0:       pop <= 1'b1;
			1:       pop <= stall_pat[4'(pop_cyc)];
			default: pop <= ($urandom_range(0, 2) == 0);
		endcase
	end

	// every accepted result is matched against the oldest owed one
	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing owed: green %0d mismatches %0d",
					$time, result.green_level, result.mismatch_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (result.green_level !== want.green_level) begin
					$display("%0t: green_level expected %0d actual %0d",
						$time, want.green_level, result.green_level);
					error_count++;
				end
				if (result.mismatch_count !== want.mismatch_count) begin
					$display("%0t: mismatch_count expected %0d actual %0d",
						$time, want.mismatch_count, result.mismatch_count);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles where no request of any kind goes through
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results still owed",
				$time, idle_cycles, pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		item        = '0;
		pop         = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_PACK_MODE;
		cfg_data    = 8'd0;
		cur_mode    = MODE_INTENSITY;
		cur_count   = 8'd2;
		ref_pixel   = 32'd0;
		diff_cnt    = 8'd0;
		src_idx     = 8'd0;
		items_sent  = 0;
		results_checked = 0;
		cfg_writes  = 0;
		error_count = 0;
		idle_cycles = 0;
		burst_left  = 0;
		steady_sender = 1'b0;
		pop_mode    = 0;
		stall_pat   = 16'hffff;
		pop_cyc     = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_config();
		test_pack_modes();
		test_padding();
		test_few_sources();
		test_mid_position_changes();
		test_random_traffic();

		// drain and give the divider time to show anything extra
		wait_idle();
		repeat (40) @(negedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			error_count++;
		end

		$display("run covered %0d source requests, %0d checked results, %0d register writes",
			items_sent, results_checked, cfg_writes);
		$display("all pack modes, padding, 0 to 255 sources and mid-position changes exercised");
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", error_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> sim.f
src/mspd_pkg.sv
src/mspd_front.sv
src/mspd_fifo.sv
src/mspd_divider.sv
src/multi_source_pixel_diff.sv
sim/testbench.sv
